// ----- hw/rtl/fwc_pkg.sv -----
package fwc_pkg;

    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_ENQ    = 2'd0,
        REQ_DEQ    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_CANCEL = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ----- hw/rtl/fwc_dp.sv -----
module fwc_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fwc_pkg::cmd_t               cmd,
    input  logic [1:0]                  req_type,
    input  logic signed [31:0]          value,
    output logic [1:0]                  status,
    output logic signed [31:0]          data,
    output logic [fwc_pkg::CNT_W-1:0]   count,
    output logic                        is_empty,
    output logic                        is_full
);
    import fwc_pkg::*;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    req_t             req_reg;
    logic [WIDTH-1:0] word_reg;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] match_next;

    status_t          status_reg;
    status_t          status_next;
    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;
    logic [CNT_W-1:0] cnt_out_reg;
    logic             empty_reg;
    logic             full_reg;

    logic [DEPTH-1:0] rem;
    logic [DEPTH-1:0] shift_mask;
    logic             acc;
    logic             found;
    logic             q_empty;
    logic             q_full;
    logic             do_push;

    // per-cell compare, taken at accept
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (entry_reg[i] == value[WIDTH-1:0]) && (CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        acc = 1'b0;
        for (int i = 0; i < DEPTH; i++)
        begin
            acc    = acc | match_reg[i];
            rem[i] = acc;
        end
        found       = |match_reg;
        q_empty     = (count_reg == '0);
        q_full      = (count_reg == CNT_W'(DEPTH));
        status_next = ST_OK;
        data_next   = '0;
        count_next  = count_reg;
        do_push     = 1'b0;
        shift_mask  = '0;
        case (req_reg)
            REQ_ENQ:
            begin
                if (q_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    do_push    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_DEQ:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_next  = entry_reg[0];
                    shift_mask = '1;
                    count_next = count_reg - 1'b1;
                end
            end
            REQ_PEEK:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    data_next = entry_reg[0];
                end
            end
            REQ_CANCEL:
            begin
                if (q_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (found)
                begin
                    shift_mask = rem;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_t'(req_type);
            word_reg  <= value[WIDTH-1:0];
            match_reg <= match_next;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            data_reg    <= data_next;
            cnt_out_reg <= count_next;
            empty_reg   <= (count_next == '0);
            full_reg    <= (count_next == CNT_W'(DEPTH));
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (shift_mask[i])
                begin
                    entry_reg[i] <= entry_reg[i+1];
                end
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (do_push && (count_reg == CNT_W'(i)))
                begin
                    entry_reg[i] <= word_reg;
                end
            end
        end
    end

    assign status   = status_reg;
    assign data     = DATA_W'(data_reg);
    assign count    = cnt_out_reg;
    assign is_empty = empty_reg;
    assign is_full  = full_reg;

endmodule

// ----- hw/rtl/fwc_ctrl.sv -----
module fwc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output fwc_pkg::cmd_t  cmd
);
    import fwc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // result register must be free (or draining) to take the beat
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/fifo_with_cancel_by_value.sv -----
// out_valid is set by the execute step, which follows the accept once the result is free.
// Each request is accepted, then executed in the cell array; the next request is taken
// after that execute step, while the previous result waits in the output register.
// Cancel compares all cells in the accept cycle and shifts in the execute cycle.
// Reset (rst_n, async, active low) empties the queue and clears the handshake state.
module fifo_with_cancel_by_value
    import fwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           req_type,
    input  logic signed [31:0]   value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic signed [31:0]   data,
    output logic [CNT_W-1:0]     count,
    output logic                 is_empty,
    output logic                 is_full
);

    cmd_t cmd;

    fwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    fwc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_type (req_type),
        .value    (value),
        .status   (status),
        .data     (data),
        .count    (count),
        .is_empty (is_empty),
        .is_full  (is_full)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while one still executes");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CNT_W'(DEPTH)))
        else $error("count beyond depth");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((is_empty == (count == '0)) && (is_full == (count == CNT_W'(DEPTH)))))
        else $error("flags disagree with count");

    a_result_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without an execute cycle");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import fwc_pkg::*;

    typedef struct packed {
        status_t            st;
        logic [31:0]        word;
        logic [CNT_W-1:0]   cnt;
        logic               empty;
        logic               full;
    } response_t;

    class cancel_fifo_scoreboard;
        logic [31:0] held[$];
        response_t   pending_results[$];
        int          errors;
        int          checked;
        int          status_seen[4];

        function void note_request(req_t r, logic [31:0] v);
            response_t e;
            int        hit;
            e.st   = ST_OK;
            e.word = '0;
            case (r)
                REQ_ENQ:
                    if (held.size() >= DEPTH)
                        e.st = ST_FULL;
                    else
                        held.push_back(v);
                REQ_DEQ:
                    if (held.size() == 0)
                        e.st = ST_EMPTY;
                    else
                        e.word = held.pop_front();
                REQ_PEEK:
                    if (held.size() == 0)
                        e.st = ST_EMPTY;
                    else
                        e.word = held[0];
                default:
                    if (held.size() == 0)
                        e.st = ST_EMPTY;
                    else
                    begin
                        hit = -1;
                        foreach (held[k])
                            if (hit < 0 && held[k] == v)
                                hit = k;
                        if (hit < 0)
                            e.st = ST_NOTFOUND;
                        else
                            held.delete(hit);
                    end
            endcase
            e.cnt   = CNT_W'(held.size());
            e.empty = (held.size() == 0);
            e.full  = (held.size() == DEPTH);
            pending_results.push_back(e);
        endfunction

        function logic [31:0] any_held_word();
            return held[$urandom_range(0, held.size() - 1)];
        endfunction

        function void check_response(status_t st, logic [31:0] d, logic [CNT_W-1:0] c,
                                     logic em, logic fu);
            response_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, status %s data %0d",
                         $time, st.name(), $signed(d));
                errors++;
                return;
            end
            e = pending_results.pop_front();
            checked++;
            status_seen[e.st]++;
            if (st !== e.st)
            begin
                $display("%0t: status expected %s, got %s", $time, e.st.name(), st.name());
                errors++;
            end
            if (d !== e.word)
            begin
                $display("%0t: data expected %0d, got %0d", $time, $signed(e.word), $signed(d));
                errors++;
            end
            if (c !== e.cnt)
            begin
                $display("%0t: count expected %0d, got %0d", $time, e.cnt, c);
                errors++;
            end
            if (em !== e.empty)
            begin
                $display("%0t: is_empty expected %0b, got %0b", $time, e.empty, em);
                errors++;
            end
            if (fu !== e.full)
            begin
                $display("%0t: is_full expected %0b, got %0b", $time, e.full, fu);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          req_type;
    logic signed [31:0]  value;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          status;
    logic signed [31:0]  data;
    logic [CNT_W-1:0]    count;
    logic                is_empty;
    logic                is_full;

    cancel_fifo_scoreboard sb;
    bit                    quiet_phase;
    int                    sent;

    fifo_with_cancel_by_value dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .data      (data),
        .count     (count),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 7);
        if (r < 40)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_request(input req_t r, input logic [31:0] v);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        req_type = r;
        value    = v;
        do @(posedge clk); while (!in_ready);
        sb.note_request(r, v);
        sent++;
    endtask

    task automatic send_random(input bit filling);
        int    r;
        req_t  op;
        logic [31:0] w;
        r = $urandom_range(0, 99);
        if (filling)
            op = (r < 60) ? REQ_ENQ : (r < 70) ? REQ_DEQ : (r < 80) ? REQ_PEEK : REQ_CANCEL;
        else
            op = (r < 20) ? REQ_ENQ : (r < 65) ? REQ_DEQ : (r < 75) ? REQ_PEEK : REQ_CANCEL;
        if (op == REQ_CANCEL && sb.held.size() > 0 && $urandom_range(0, 99) < 60)
            w = sb.any_held_word();
        else
            w = pick_word();
        send_request(op, w);
    endtask

    // receiver: random stalls, plus one long hold-off so the queue backs up
    initial
    begin
        int  gap;
        bit  held_off;
        out_ready = 1'b0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = pick_gap();
            if (!held_off && sb.checked >= 300)
            begin
                held_off = 1'b1;
                gap      = 80;
            end
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_response(status_t'(status), data, count, is_empty, is_full);
        end
    end

    initial
    begin
        #4_000_000;
        $display("%0t: timeout", $time);
        $display("** fifo_with_cancel_by_value: FAILED **");
        $finish;
    end

    initial
    begin
        int waited;
        sb          = new();
        quiet_phase = 1'b0;
        sent        = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_ENQ;
        value       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty queue, extremes, only-entry cancel, duplicates, not found
        send_request(REQ_DEQ,    32'd0);
        send_request(REQ_PEEK,   32'd0);
        send_request(REQ_CANCEL, 32'd0);
        send_request(REQ_ENQ,    32'h7fff_ffff);
        send_request(REQ_PEEK,   32'hffff_ffff);
        send_request(REQ_CANCEL, 32'h7fff_ffff);
        send_request(REQ_PEEK,   32'd0);
        send_request(REQ_ENQ,    32'h8000_0000);
        send_request(REQ_ENQ,    32'd5);
        send_request(REQ_ENQ,    32'h8000_0000);
        send_request(REQ_ENQ,    32'hffff_ffff);
        send_request(REQ_CANCEL, 32'h8000_0000);
        send_request(REQ_PEEK,   32'd0);
        send_request(REQ_CANCEL, 32'd99);
        send_request(REQ_DEQ,    32'd0);
        send_request(REQ_DEQ,    32'd0);
        send_request(REQ_DEQ,    32'd0);
        send_request(REQ_DEQ,    32'd0);
        send_request(REQ_ENQ,    32'd0);
        send_request(REQ_CANCEL, 32'd0);

        for (int i = 0; i < 1100; i++)
        begin
            quiet_phase = ((i % 150) >= 110);
            send_random(((i / 80) % 2) == 0);
        end
        @(negedge clk);
        in_valid = 1'b0;

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending_results.size());
            sb.errors++;
        end

        $display("Sent %0d requests, checked %0d results", sent, sb.checked);
        $display("ok %0d, full drops %0d, empty %0d, cancel misses %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOTFOUND]);
        if (sb.errors == 0)
            $display("** fifo_with_cancel_by_value: PASSED **");
        else
            $display("** fifo_with_cancel_by_value: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/fwc_pkg.sv
hw/rtl/fwc_dp.sv
hw/rtl/fwc_ctrl.sv
hw/rtl/fifo_with_cancel_by_value.sv
tb/tb.sv
